// ===== rtl/mnee_pkg.sv =====
// Package for the note event encoder: shared constants and types.
// No dependencies.
package mnee_pkg;
    localparam logic [4:0] NO_CHAN      = 5'd31;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_CTRL      = 8'hb0;
    localparam logic [7:0] ST_PROG      = 8'hc0;
    localparam logic [7:0] CC_DAMPER    = 8'h40;
    localparam logic [7:0] CC_VOLUME    = 8'h07;
    localparam logic [7:0] VOLUME_VAL   = 8'd80;
    localparam logic [7:0] CC_PAN       = 8'h0a;
    localparam logic [4:0] DRUM_CHAN    = 5'd9;
    localparam logic [6:0] CLAMP_NOTE   = 7'd60;
    localparam logic [6:0] NOTE_LIMIT   = 7'd100;

    localparam logic [1:0] REG_TICKS    = 2'd0;
    localparam logic [1:0] REG_UNITS    = 2'd1;
    localparam logic [1:0] REG_PAN_EVEN = 2'd2;
    localparam logic [1:0] REG_PAN_ODD  = 2'd3;

    // delta divider request and result
    typedef struct packed {
        logic        start;
        logic [41:0] dividend;
        logic [7:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;
endpackage

// ===== rtl/mnee_divider.sv =====
// Restoring divider, one quotient bit per cycle, saturating at 32 bits.
// Depends on mnee_pkg.
module mnee_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  mnee_pkg::div_req_t  req,
    output mnee_pkg::div_rsp_t  rsp
);
    import mnee_pkg::*;

    logic [41:0] quo_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [8:0]  trial;

    assign trial = {rem_reg, quo_reg[41]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd42;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= (req.divisor == 8'd0) ? 8'd1 : req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[8])
            begin
                rem_reg <= trial[7:0];
                quo_reg <= {quo_reg[40:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[6:0], quo_reg[41]};
                quo_reg <= {quo_reg[40:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = (quo_reg[41:32] != '0) ? 32'hffff_ffff : quo_reg[31:0];
endmodule

// ===== rtl/mnee_voice_mem.sv =====
// Per-voice channel and instrument memory with registered read.
// Depends on nothing; widths follow the voice count.
module mnee_voice_mem #(
    parameter int VOICES = 64
) (
    input  logic                      clk,
    input  logic [$clog2(VOICES)-1:0] rd_addr,
    output logic [12:0]               rd_data,
    input  logic                      wr_en,
    input  logic [$clog2(VOICES)-1:0] wr_addr,
    input  logic [12:0]               wr_data
);
    // {epoch, channel[4:0], instrument[6:0]} -- epoch bit marks written since reset
    logic [12:0] mem [VOICES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/midi_note_event_encoder.sv =====
// Top level of the note event encoder: control sequencer and byte output.
// Depends on mnee_pkg, mnee_divider and mnee_voice_mem.
//
// Each request becomes 4 to 21 bytes on the output channel, one per cycle when
// the sink is ready. The delta time is scaled by a 42-step bit-serial divider,
// and the voice state (channel and instrument) sits in a one-port-read memory
// read once per request and written back once per non-sampled request. After
// reset the voice memory is cleared by a sweep over all COLORS*GROUPS entries,
// during which no request is taken. No request is taken until the last byte.
module midi_note_event_encoder #(
    parameter int COLORS = 8,
    parameter int GROUPS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        note_start,
    input  logic [2:0]  color,
    input  logic [2:0]  group,
    input  logic [6:0]  instrument,
    input  logic        sampled,
    input  logic [23:0] event_time,
    input  logic [6:0]  note_number,
    input  logic [6:0]  velocity,
    input  logic        track_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic        channels_exhausted
);
    import mnee_pkg::*;

    localparam int VOICES = COLORS * GROUPS;
    localparam int VW     = $clog2(VOICES);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]  state_reg;
    logic [VW-1:0] clr_reg;
    logic [15:0] ticks_reg;
    logic [7:0]  units_reg;
    logic [6:0]  pan_even_reg, pan_odd_reg;
    logic [4:0]  last_chan_reg;
    logic [23:0] last_time_reg;
    logic        warned_reg;

    logic        start_reg, smp_reg, col0_reg;
    logic [6:0]  instr_reg, note_reg, vel_reg;
    logic [23:0] time_reg;
    logic [VW-1:0] idx_reg;

    logic [4:0]  chan_reg;
    logic        prog_reg;
    logic [31:0] delta_reg;
    logic [2:0]  vlq_top_reg;
    logic [4:0]  pos_reg;
    logic [4:0]  nbytes_reg;

    logic [12:0] rd_data;
    logic        wr_en;
    logic [VW-1:0] wr_addr, rd_addr;
    logic [12:0] wr_data;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic [VW-1:0] idx_in;
    logic [23:0] diff;
    logic [4:0]  next_chan;
    logic        mem_valid;
    logic [4:0]  mem_chan;

    logic [7:0]  byte_sel;
    logic [2:0]  vlq_top;
    logic [4:0]  vlq_pos;
    logic        in_vlq;

    // small modulo by repeated subtraction; operand is only 3 bits wide
    function automatic logic [4:0] reduce_mod(logic [2:0] v, int m);
        logic [4:0] r;
        r = {2'b00, v};
        for (int i = 0; i < 8; i++)
            if (32'(r) >= m)
                r = r - 5'(m);
        return r;
    endfunction

    assign idx_in = VW'(32'(reduce_mod(color, COLORS)) +
                        32'(reduce_mod(group, GROUPS)) * COLORS);
    assign rd_addr = idx_in;
    assign in_ready = (state_reg == S_IDLE);

    mnee_voice_mem #(.VOICES(VOICES)) u_mem (
        .clk(clk), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    mnee_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign mem_valid = rd_data[12];
    assign mem_chan  = mem_valid ? rd_data[11:7] : NO_CHAN;
    assign next_chan = (last_chan_reg == NO_CHAN) ? 5'd0 :
                       (last_chan_reg == 5'd8) ? 5'd10 : last_chan_reg + 5'd1;
    assign diff      = time_reg - last_time_reg;

    // write port: clear sweep or voice update in S_READ for non-sampled requests
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '0;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end
        else if (state_reg == S_READ && !smp_reg)
        begin
            wr_en = 1'b1;
            if (mem_chan != NO_CHAN)
                wr_data = {1'b1, mem_chan, instr_reg};
            else if (last_chan_reg == 5'd15)
                wr_data = {1'b1, NO_CHAN, instr_reg};
            else
                wr_data = {1'b1, next_chan, instr_reg};
        end
    end

    // 24x16 product, times four by the appended zeros
    always_comb
    begin
        dreq.start    = (state_reg == S_READ);
        dreq.dividend = (time_reg > last_time_reg) ?
                        {40'(diff) * 40'(ticks_reg), 2'b00} : 42'd0;
        dreq.divisor  = units_reg;
    end

    // first VLQ group index (0..4)
    always_comb
    begin
        if (drsp.quotient[31:28] != '0)      vlq_top = 3'd4;
        else if (drsp.quotient[27:21] != '0) vlq_top = 3'd3;
        else if (drsp.quotient[20:14] != '0) vlq_top = 3'd2;
        else if (drsp.quotient[13:7] != '0)  vlq_top = 3'd1;
        else                                 vlq_top = 3'd0;
    end

    // byte stream layout: prefix (7 if program change), vlq, tail
    always_comb
    begin
        logic [4:0] p;
        logic [4:0] vs;
        logic [4:0] k;
        logic [34:0] sh;
        p  = pos_reg;
        vs = prog_reg ? 5'd7 : 5'd0;
        in_vlq  = (p >= vs) && (p <= vs + 5'(vlq_top_reg));
        vlq_pos = 5'(vlq_top_reg) - (p - vs);
        sh = 35'(delta_reg) >> (7 * vlq_pos);
        k  = p - vs - 5'(vlq_top_reg) - 5'd1;
        byte_sel = '0;
        if (in_vlq)
            byte_sel = {(vlq_pos != 5'd0), sh[6:0]};
        else if (prog_reg && p < 5'd7)
        begin
            case (p)
                5'd1:    byte_sel = ST_CTRL + 8'(chan_reg);
                5'd2:    byte_sel = CC_DAMPER;
                5'd5:    byte_sel = CC_VOLUME;
                5'd6:    byte_sel = VOLUME_VAL;
                default: byte_sel = 8'd0;
            endcase
        end
        else if (prog_reg && k < 5'd6)
        begin
            case (k)
                5'd0:    byte_sel = CC_PAN;
                5'd1:    byte_sel = {1'b0, col0_reg ? pan_odd_reg : pan_even_reg};
                5'd3:    byte_sel = ST_PROG + 8'(chan_reg);
                5'd4:    byte_sel = {1'b0, instr_reg};
                default: byte_sel = 8'd0;
            endcase
        end
        else
        begin
            if (prog_reg)
                k = k - 5'd6;
            case (k)
                5'd0:    byte_sel = (start_reg ? ST_NOTE_ON : ST_NOTE_OFF) + 8'(chan_reg);
                5'd1:    byte_sel = {1'b0, smp_reg ? instr_reg :
                                     (note_reg >= NOTE_LIMIT ? CLAMP_NOTE : note_reg)};
                default: byte_sel = {1'b0, start_reg ? vel_reg : 7'd0};
            endcase
        end
    end

    assign out_valid          = (state_reg == S_EMIT);
    assign out_byte           = byte_sel;
    assign last_byte          = (pos_reg == nbytes_reg);
    assign channels_exhausted = warned_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            ticks_reg     <= 16'd96;
            units_reg     <= 8'd4;
            pan_even_reg  <= 7'd30;
            pan_odd_reg   <= 7'd100;
            last_chan_reg <= NO_CHAN;
            last_time_reg <= '0;
            warned_reg    <= 1'b0;
            pos_reg       <= '0;
            chan_reg      <= '0;
            prog_reg      <= 1'b0;
            delta_reg     <= '0;
            vlq_top_reg   <= '0;
            nbytes_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TICKS:    ticks_reg    <= cfg_data;
                    REG_UNITS:    units_reg    <= cfg_data[7:0];
                    REG_PAN_EVEN: pan_even_reg <= cfg_data[6:0];
                    REG_PAN_ODD:  pan_odd_reg  <= cfg_data[6:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + VW'(1);
                    if (32'(clr_reg) == VOICES - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_READ;
                        if (track_start)
                            last_time_reg <= '0;
                    end
                end
                S_READ:
                begin
                    last_time_reg <= time_reg;
                    if (smp_reg)
                        prog_reg <= 1'b0;
                    else
                        prog_reg <= !mem_valid || rd_data[6:0] != instr_reg;
                    if (smp_reg)
                        chan_reg <= DRUM_CHAN;
                    else if (mem_chan != NO_CHAN)
                        chan_reg <= {1'b0, mem_chan[3:0]};
                    else if (last_chan_reg == 5'd15)
                    begin
                        chan_reg   <= 5'd0;
                        warned_reg <= 1'b1;
                    end
                    else
                    begin
                        chan_reg      <= next_chan;
                        last_chan_reg <= next_chan;
                    end
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (drsp.done)
                    begin
                        delta_reg   <= drsp.quotient;
                        vlq_top_reg <= vlq_top;
                        nbytes_reg  <= (prog_reg ? 5'd13 : 5'd0) + 5'(vlq_top) + 5'd3;
                        pos_reg     <= '0;
                        state_reg   <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        pos_reg <= pos_reg + 5'd1;
                        if (last_byte)
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            start_reg <= note_start;
            smp_reg   <= sampled;
            col0_reg  <= color[0];
            instr_reg <= instrument;
            note_reg  <= note_number;
            vel_reg   <= velocity;
            time_reg  <= event_time;
            idx_reg   <= idx_in;
        end
    end

    a_warn_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        warned_reg |=> warned_reg) else $error("warning flag cleared");
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during output");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_byte) |=> in_ready)
        else $error("no return to idle after last byte");
endmodule
